/* rtl/core/fsc_pkg.sv */
// Package for the frustum sphere culling block: field widths, plane count,
// command and classification codes, and the per-plane flag struct.
// No dependencies.
`timescale 1ns / 1ps

package fsc_pkg;

  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned PIDX_W      = 3;
  localparam int unsigned NORM_W      = 16;
  localparam int unsigned COORD_W     = 24;
  localparam int unsigned RAD_W       = 23;
  localparam int unsigned FRAC_SHIFT  = 14;
  localparam int unsigned PROD_W      = NORM_W + COORD_W;
  localparam int unsigned SUM_W       = PROD_W + 2;
  localparam int unsigned SHR_W       = SUM_W - FRAC_SHIFT;
  localparam int unsigned DIST_W      = SHR_W + 1;
  localparam int unsigned IN_DATA_W   = 176;
  localparam int unsigned OUT_DATA_W  = 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_OUTSIDE    = 2'd0,
    CLS_INTERSECTS = 2'd1,
    CLS_INSIDE     = 2'd2
  } cls_e;

  typedef struct packed {
    logic outside;
    logic crossing;
  } plane_flags_t;

endpackage

/* rtl/core/frustum_sphere_cull.sv */
// Top level of the frustum sphere culling block: input register, plane store,
// product stage and result register. Depends on fsc_pkg and fsc_plane_dist.
`timescale 1ns / 1ps

// Usage:
// The slave channel carries one item per transfer. tuser selects the command:
// a load writes one plane (normal and offset) into the plane store and gives
// no result; a test brings a sphere and gives one classification on the
// master channel. Loads with a plane index at or above the plane count are
// dropped. All planes are evaluated in parallel, so the block accepts one
// item per cycle unless the master side stalls and the pipeline is full. A
// test passes from the input register into the product register and then
// into the result register. A load takes effect when it leaves the input
// register, in order with the tests around it.
// Reset clears the pipeline and sets every plane to zero, which makes any
// sphere with a nonzero radius intersect. When the master side stalls, each
// stage keeps filling until the pipeline holds three items, and only then
// does s_axis_tready fall; it rises again in the cycle the result is taken.

module frustum_sphere_cull import fsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: plane_index, normal_x, normal_y, normal_z, plane_offset,
  // center_x, center_y, center_z, radius, zero fill.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: cmd.
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: classification, zero fill.
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Input register.
  logic                      s1_valid_q;
  cmd_e                      s1_cmd_q;
  logic [PIDX_W-1:0]         s1_idx_q;
  logic signed [NORM_W-1:0]  s1_nx_q, s1_ny_q, s1_nz_q;
  logic signed [COORD_W-1:0] s1_off_q;
  logic signed [COORD_W-1:0] s1_cx_q, s1_cy_q, s1_cz_q;
  logic [RAD_W-1:0]          s1_rad_q;

  // Plane store.
  logic signed [NORM_W-1:0]  nx_q [PLANE_COUNT];
  logic signed [NORM_W-1:0]  ny_q [PLANE_COUNT];
  logic signed [NORM_W-1:0]  nz_q [PLANE_COUNT];
  logic signed [COORD_W-1:0] off_q [PLANE_COUNT];

  // Product register.
  logic                      s2_valid_q;
  logic signed [PROD_W-1:0]  px_q [PLANE_COUNT];
  logic signed [PROD_W-1:0]  py_q [PLANE_COUNT];
  logic signed [PROD_W-1:0]  pz_q [PLANE_COUNT];
  logic signed [COORD_W-1:0] s2_off_q [PLANE_COUNT];
  logic [RAD_W-1:0]          s2_rad_q;

  // Result register.
  logic out_valid_q;
  cls_e out_cls_q;
  cls_e out_cls_d;

  logic s1_adv, s2_adv, s1_load, s1_test, s_xfer;
  plane_flags_t flags [PLANE_COUNT];
  logic any_out, any_cross;

  assign s1_load       = s1_valid_q && (s1_cmd_q == CMD_LOAD);
  assign s1_test       = s1_valid_q && (s1_cmd_q == CMD_TEST);
  assign s2_adv        = s2_valid_q && (!out_valid_q || m_axis_tready);
  assign s1_adv        = s1_load || (s1_test && (!s2_valid_q || s2_adv));
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cmd_q   <= CMD_LOAD;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
      s1_cmd_q   <= cmd_e'(s_axis_tuser);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_idx_q <= s_axis_tdata[2:0];
      s1_nx_q  <= s_axis_tdata[18:3];
      s1_ny_q  <= s_axis_tdata[34:19];
      s1_nz_q  <= s_axis_tdata[50:35];
      s1_off_q <= s_axis_tdata[74:51];
      s1_cx_q  <= s_axis_tdata[98:75];
      s1_cy_q  <= s_axis_tdata[122:99];
      s1_cz_q  <= s_axis_tdata[146:123];
      s1_rad_q <= s_axis_tdata[169:147];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        nx_q[p]  <= '0;
        ny_q[p]  <= '0;
        nz_q[p]  <= '0;
        off_q[p] <= '0;
      end
    end else if (s1_load) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        if (5'(s1_idx_q) == 5'(p)) begin
          nx_q[p]  <= s1_nx_q;
          ny_q[p]  <= s1_ny_q;
          nz_q[p]  <= s1_nz_q;
          off_q[p] <= s1_off_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_valid_q || s2_adv) begin
      s2_valid_q <= s1_test;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_test && (!s2_valid_q || s2_adv)) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        px_q[p]     <= PROD_W'(nx_q[p]) * PROD_W'(s1_cx_q);
        py_q[p]     <= PROD_W'(ny_q[p]) * PROD_W'(s1_cy_q);
        pz_q[p]     <= PROD_W'(nz_q[p]) * PROD_W'(s1_cz_q);
        s2_off_q[p] <= off_q[p];
      end
      s2_rad_q <= s1_rad_q;
    end
  end

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
    fsc_plane_dist u_dist (
      .prod_x_i (px_q[g]),
      .prod_y_i (py_q[g]),
      .prod_z_i (pz_q[g]),
      .offset_i (s2_off_q[g]),
      .radius_i (s2_rad_q),
      .flags_o  (flags[g])
    );
  end

  always_comb begin
    any_out   = 1'b0;
    any_cross = 1'b0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      any_out   = any_out | flags[p].outside;
      any_cross = any_cross | flags[p].crossing;
    end
    priority if (any_out) begin
      out_cls_d = CLS_OUTSIDE;
    end else if (any_cross) begin
      out_cls_d = CLS_INTERSECTS;
    end else begin
      out_cls_d = CLS_INSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_cls_q   <= CLS_OUTSIDE;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        out_cls_q <= out_cls_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - 2){1'b0}}, out_cls_q};

  a_load_not_forwarded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(s1_test))
    else $error("product stage filled without a test item");

  a_ready_low_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_test && s2_valid_q && out_valid_q))
    else $error("input stalled while the pipeline had room");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_adv |=> out_valid_q)
    else $error("advanced test produced no result");

endmodule

/* rtl/core/fsc_plane_dist.sv */
// Signed distance of a sphere center to one plane from registered products,
// with saturation and the outside and crossing tests against the radius.
// Depends on fsc_pkg.
`timescale 1ns / 1ps

module fsc_plane_dist import fsc_pkg::*; (
  input  logic signed [PROD_W-1:0]  prod_x_i,
  input  logic signed [PROD_W-1:0]  prod_y_i,
  input  logic signed [PROD_W-1:0]  prod_z_i,
  input  logic signed [COORD_W-1:0] offset_i,
  input  logic        [RAD_W-1:0]   radius_i,
  output plane_flags_t              flags_o
);

  localparam logic signed [DIST_W-1:0] DMax = DIST_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [DIST_W-1:0] DMin = -DIST_W'(1 << (COORD_W - 1));

  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   sum_shr;
  logic signed [DIST_W-1:0]  dist_wide;
  logic signed [COORD_W-1:0] dist_sat;
  logic signed [COORD_W:0]   neg_radius;
  logic        [COORD_W-1:0] abs_dist;

  always_comb begin
    sum       = SUM_W'(prod_x_i) + SUM_W'(prod_y_i) + SUM_W'(prod_z_i);
    sum_shr   = sum >>> FRAC_SHIFT;
    dist_wide = DIST_W'(signed'(sum_shr[SHR_W-1:0])) + DIST_W'(offset_i);
    if (dist_wide > DMax) begin
      dist_sat = COORD_W'(DMax);
    end else if (dist_wide < DMin) begin
      dist_sat = COORD_W'(DMin);
    end else begin
      dist_sat = dist_wide[COORD_W-1:0];
    end
    neg_radius = -signed'({2'b00, radius_i});
    abs_dist   = dist_sat[COORD_W-1] ? (~dist_sat + 1'b1) : dist_sat;
    flags_o.outside  = (signed'((COORD_W + 1)'(dist_sat)) < neg_radius);
    flags_o.crossing = (abs_dist < {1'b0, radius_i});
  end

endmodule

/* tb/sv/fsc_cull_checker.sv */
// Checker for frustum_sphere_cull: watches both stream channels, keeps its own plane store,
// predicts the classification of each sphere test and compares it with the returned one.
// Depends on fsc_pkg.
`timescale 1ns / 1ps

module fsc_cull_checker import fsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int unsigned           mismatch_count_o,
  output int unsigned           results_pending_o
);

  typedef struct packed {
    logic [5:0]         pad;
    logic [22:0]        radius;
    logic signed [23:0] center_z;
    logic signed [23:0] center_y;
    logic signed [23:0] center_x;
    logic signed [23:0] plane_offset;
    logic signed [15:0] normal_z;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_x;
    logic [2:0]         plane_index;
  } sphere_item_t;

  localparam longint DIST_MAX = 64'sd8388607;
  localparam longint DIST_MIN = -64'sd8388608;
  localparam int unsigned REPORT_LIMIT = 10;

  logic signed [15:0] norm_x [PLANE_COUNT];
  logic signed [15:0] norm_y [PLANE_COUNT];
  logic signed [15:0] norm_z [PLANE_COUNT];
  logic signed [23:0] plane_ofs [PLANE_COUNT];

  cls_e         cls_queue [$];
  sphere_item_t in_item;
  cls_e         want_cls;
  logic [1:0]   got_cls;
  int unsigned  mismatches;

  initial begin
    mismatches        = 0;
    mismatch_count_o  = 0;
    results_pending_o = 0;
  end

  // Distance to each plane is floor(dot / 2^14) + offset, saturated to 24 bits.
  function automatic cls_e classify_sphere(input logic signed [23:0] cx,
                                           input logic signed [23:0] cy,
                                           input logic signed [23:0] cz,
                                           input logic [22:0] rad);
    longint dot, plane_dist, rr, mag;
    logic   any_out, any_cross;
    int     p;
    any_out   = 1'b0;
    any_cross = 1'b0;
    rr        = {41'd0, rad};
    for (p = 0; p < PLANE_COUNT; p++) begin
      dot = longint'(norm_x[p]) * longint'(cx) + longint'(norm_y[p]) * longint'(cy)
          + longint'(norm_z[p]) * longint'(cz);
      plane_dist = (dot >>> FRAC_SHIFT) + longint'(plane_ofs[p]);
      if (plane_dist > DIST_MAX) plane_dist = DIST_MAX;
      if (plane_dist < DIST_MIN) plane_dist = DIST_MIN;
      if (plane_dist < -rr) any_out = 1'b1;
      mag = (plane_dist < 0) ? -plane_dist : plane_dist;
      if (mag < rr) any_cross = 1'b1;
    end
    if (any_out) return CLS_OUTSIDE;
    if (any_cross) return CLS_INTERSECTS;
    return CLS_INSIDE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        norm_x[p]    = '0;
        norm_y[p]    = '0;
        norm_z[p]    = '0;
        plane_ofs[p] = '0;
      end
      cls_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_cls = m_axis_tdata[1:0];
        if (cls_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] unexpected result transfer: actual %0d", $realtime, got_cls);
          end
        end else begin
          want_cls = cls_queue.pop_front();
          if (got_cls !== want_cls) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("[%0t] classification mismatch: expected %0d actual %0d",
                       $realtime, want_cls, got_cls);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_item = s_axis_tdata;
        if (cmd_e'(s_axis_tuser) == CMD_LOAD) begin
          if (in_item.plane_index < PLANE_COUNT) begin
            norm_x[in_item.plane_index]    = in_item.normal_x;
            norm_y[in_item.plane_index]    = in_item.normal_y;
            norm_z[in_item.plane_index]    = in_item.normal_z;
            plane_ofs[in_item.plane_index] = in_item.plane_offset;
          end
        end else begin
          cls_queue.push_back(classify_sphere(in_item.center_x, in_item.center_y,
                                              in_item.center_z, in_item.radius));
        end
      end
    end
    mismatch_count_o  <= mismatches;
    results_pending_o <= cls_queue.size();
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top for frustum_sphere_cull: clock, reset, plane loads and sphere tests under
// three idle patterns, a stall watchdog and the verdict.
// Depends on fsc_pkg, frustum_sphere_cull and fsc_cull_checker.
`timescale 1ns / 1ps

module tb;
  import fsc_pkg::*;

  typedef struct packed {
    logic [5:0]         pad;
    logic [22:0]        radius;
    logic signed [23:0] center_z;
    logic signed [23:0] center_y;
    logic signed [23:0] center_x;
    logic signed [23:0] plane_offset;
    logic signed [15:0] normal_z;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_x;
    logic [2:0]         plane_index;
  } sphere_item_t;

  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int          NORM_ONE       = 16384;
  localparam int          Q_MAX          = 8388607;
  localparam int          Q_MIN          = -8388608;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned items_sent;
  int unsigned stall_cycles;
  int          box_ext;

  frustum_sphere_cull u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fsc_cull_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("frustum_sphere_cull regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int rand_span(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic send_item(input cmd_e cmd, input sphere_item_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // The sphere fields of a load are ignored by the block, so they carry random bits.
  task automatic load_plane(input int idx, input int nx, input int ny, input int nz,
                            input int ofs);
    sphere_item_t item;
    item              = '0;
    item.plane_index  = idx[2:0];
    item.normal_x     = nx[15:0];
    item.normal_y     = ny[15:0];
    item.normal_z     = nz[15:0];
    item.plane_offset = ofs[23:0];
    item.center_x     = $urandom();
    item.center_y     = $urandom();
    item.center_z     = $urandom();
    item.radius       = $urandom();
    send_item(CMD_LOAD, item);
    if (idx[2:0] < PLANE_COUNT) items_sent++;
  endtask

  task automatic test_sphere(input int cx, input int cy, input int cz, input int rad);
    sphere_item_t item;
    item              = '0;
    item.plane_index  = $urandom();
    item.normal_x     = $urandom();
    item.normal_y     = $urandom();
    item.normal_z     = $urandom();
    item.plane_offset = $urandom();
    item.center_x     = cx[23:0];
    item.center_y     = cy[23:0];
    item.center_z     = cz[23:0];
    item.radius       = rad[22:0];
    send_item(CMD_TEST, item);
    items_sent++;
  endtask

  // Six planes facing inward around a box of half size box_ext, normals untilted or slightly tilted.
  task automatic load_box();
    int p, jit, axis_w;
    int comp [3];
    case ($urandom_range(3))
      0:       box_ext = $urandom_range(4096, 256);
      1:       box_ext = $urandom_range(65536, 4096);
      2:       box_ext = $urandom_range(1 << 20, 65536);
      default: box_ext = $urandom_range(8388000, 1 << 22);
    endcase
    jit = $urandom_range(1) ? 0 : $urandom_range(2048);
    for (p = 0; p < PLANE_COUNT; p++) begin
      comp[0] = rand_span(jit);
      comp[1] = rand_span(jit);
      comp[2] = rand_span(jit);
      axis_w  = NORM_ONE - int'($urandom_range(jit));
      comp[p / 2] = (p % 2 == 0) ? axis_w : -axis_w;
      load_plane(p, comp[0], comp[1], comp[2], box_ext + rand_span(jit / 8));
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned goal, pick;
    int          span, rad;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        load_box();
      end else if (pick < 20) begin
        load_plane($urandom_range(7), rand_span(NORM_ONE), rand_span(NORM_ONE),
                   rand_span(NORM_ONE),
                   ($urandom_range(2) == 0) ? int'($urandom()) : rand_span(2 * box_ext));
      end else if ($urandom_range(9) == 0) begin
        test_sphere($urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        span = (box_ext > 5592404) ? Q_MAX : box_ext + box_ext / 2;
        case ($urandom_range(9))
          0:          rad = 0;
          1:          rad = $urandom();
          2, 3, 4, 5: rad = $urandom_range(box_ext / 2);
          default:    rad = $urandom_range(box_ext);
        endcase
        test_sphere(rand_span(span), rand_span(span), rand_span(span), rad);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    stall_cycles  = 0;
    items_sent    = 0;
    box_ext       = 4096;
    src_idle_pct  = 8;
    snk_idle_pct  = 48;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Planes are all zero after reset: inside at zero radius, intersects otherwise.
    test_sphere(0, 0, 0, 0);
    test_sphere(Q_MAX, Q_MIN, 0, 1);
    test_sphere(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    load_plane(0, NORM_ONE, 0, 0, 0);
    load_plane(1, -NORM_ONE, 0, 0, 0);
    test_sphere(25600, 0, 0, 0);
    test_sphere(0, 0, 0, 0);
    // Loads to an index beyond the store must leave it untouched.
    load_plane(6, -NORM_ONE, -NORM_ONE, -NORM_ONE, Q_MIN);
    load_plane(7, -NORM_ONE, -NORM_ONE, -NORM_ONE, Q_MIN);
    test_sphere(0, 0, 0, 0);
    // Distances beyond the 24-bit range saturate in both directions.
    load_plane(2, NORM_ONE, NORM_ONE, NORM_ONE, Q_MAX);
    load_plane(3, -NORM_ONE, -NORM_ONE, -NORM_ONE, Q_MIN);
    test_sphere(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    test_sphere(Q_MIN, Q_MIN, Q_MIN, 0);
    test_sphere(Q_MIN, Q_MIN, Q_MIN, Q_MAX);
    load_plane(2, 0, 0, 0, Q_MAX);
    load_plane(3, 0, 0, 0, Q_MAX);
    load_plane(4, 0, NORM_ONE, 0, Q_MAX);
    load_plane(5, 0, 0, -NORM_ONE, Q_MIN);
    test_sphere(0, 0, Q_MIN, 0);
    test_sphere(0, Q_MIN, Q_MIN, 100);
    test_sphere(-300, 12345, -8388607, 300);

    run_random(PHASE_ITEMS);
    src_idle_pct = 48;
    snk_idle_pct = 8;
    run_random(PHASE_ITEMS);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(PHASE_ITEMS);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("frustum_sphere_cull regression: pass");
    end else begin
      $display("frustum_sphere_cull regression: fail");
    end
    $finish;
  end

endmodule
